>>> design/urde_pkg.sv
// Shared types, codes and the CRC-8 helper for the UART register datagram engine.
// Depends on nothing; every module of the engine imports it.
package urde_pkg;

   // Input command codes carried in req_tuser.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_RX    = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   // Result kinds carried in rsp_tuser.
   localparam logic [1:0] OUT_TX        = 2'd0;
   localparam logic [1:0] OUT_READ_DONE = 2'd1;
   localparam logic [1:0] OUT_REFUSED   = 2'd2;

   // Read outcomes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC     = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_SLAVE_ADDR = 1'b0;
   localparam logic CSR_TIMEOUT    = 1'b1;

   localparam int unsigned CSR_WIDTH = 16;
   localparam int unsigned REQ_TDATA_WIDTH = 48;
   localparam int unsigned RSP_TDATA_WIDTH = 48;

   localparam logic [7:0] SYNC_BYTE = 8'h05;
   localparam logic [7:0] CRC_POLY  = 8'h07;
   localparam logic [7:0] REG_WRITE_FLAG = 8'h80;

   // Datagram lengths, as the index of the final (CRC) byte.
   localparam logic [2:0] WR_LAST_IDX = 3'd7;
   localparam logic [2:0] RD_LAST_IDX = 3'd3;

   // Job queue depth.
   localparam int unsigned Q_AW = 2;
   localparam int unsigned Q_DEPTH = 1 << Q_AW;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WR_ECHO,
      PH_RD_ECHO,
      PH_RD_REPLY
   } phase_type;

   typedef enum logic [1:0] {
      JOB_WRITE,
      JOB_READ,
      JOB_DONE,
      JOB_REFUSE
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   slave;
      logic [6:0]   reg_addr;
      logic [31:0]  data;
      logic [1:0]   status;
   } job_type;

   // CRC-8, poly 0x07: message bits LSB first, register shifts MSB first.
   function automatic logic [7:0] crc_feed(input logic [7:0] crc_i, input logic [7:0] b_i);
      logic [7:0] c;
      c = crc_i;
      for (int k = 0; k < 8; k++) begin
         if (c[7] ^ b_i[k]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> design/urde_front.sv
// Front end: accepts request, received-byte and tick beats, tracks the echo and
// reply phases, and queues jobs for the back end. Depends on urde_pkg.
module urde_front #(
   parameter int unsigned TIMEOUT_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               cmd,
   input  logic [6:0]               reg_addr,
   input  logic [31:0]              write_data,
   input  logic [7:0]               rx_byte,
   input  logic [1:0]               slave_address,
   input  logic [TIMEOUT_WIDTH-1:0] timeout_ticks,
   input  logic                     q_full,
   output logic                     push,
   output urde_pkg::job_type        job
);
   import urde_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [7:0]               crc_ff, crc_in;
   logic [31:0]              word_ff, word_in;
   logic [TIMEOUT_WIDTH-1:0] wait_ff, wait_in;

   logic       accept;
   logic [3:0] cnt_inc;
   logic       expired;
   logic       is_req;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign cnt_inc    = {1'b0, cnt_ff} + 4'd1;
   assign expired    = !(wait_ff < timeout_ticks);
   assign is_req     = (cmd == CMD_WRITE) || (cmd == CMD_READ);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (cmd == CMD_WRITE) begin
                  phase_in = PH_WR_ECHO;
               end else if (cmd == CMD_READ) begin
                  phase_in = PH_RD_ECHO;
               end
            end
            PH_WR_ECHO: begin
               if ((cmd == CMD_RX && cnt_inc >= 4'd8) || (cmd == CMD_TICK && expired)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_RD_ECHO: begin
               if ((cmd == CMD_RX && cnt_inc >= 4'd4) || (cmd == CMD_TICK && expired)) begin
                  phase_in = PH_RD_REPLY;
               end
            end
            PH_RD_REPLY: begin
               if ((cmd == CMD_RX && cnt_ff == 3'd7) || (cmd == CMD_TICK && expired)) begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Counters, reply assembly and job generation.
   always_comb begin
      cnt_in  = cnt_ff;
      crc_in  = crc_ff;
      word_in = word_ff;
      wait_in = wait_ff;
      push    = 1'b0;
      job     = '{kind: JOB_REFUSE, slave: 2'd0, reg_addr: 7'd0, data: 32'd0, status: ST_OK};
      if (accept) begin
         if (is_req) begin
            push = 1'b1;
            if (phase_ff == PH_IDLE) begin
               job.kind     = (cmd == CMD_WRITE) ? JOB_WRITE : JOB_READ;
               job.slave    = slave_address;
               job.reg_addr = reg_addr;
               job.data     = (cmd == CMD_WRITE) ? write_data : 32'd0;
               cnt_in       = 3'd0;
               wait_in      = '0;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (cmd == CMD_RX) begin
               wait_in = '0;
               case (phase_ff)
                  PH_WR_ECHO: cnt_in = cnt_inc[2:0];
                  PH_RD_ECHO: begin
                     if (cnt_inc >= 4'd4) begin
                        cnt_in  = 3'd0;
                        crc_in  = 8'd0;
                        word_in = 32'd0;
                     end else begin
                        cnt_in = cnt_inc[2:0];
                     end
                  end
                  PH_RD_REPLY: begin
                     if (cnt_ff != 3'd7) begin
                        crc_in = crc_feed(crc_ff, rx_byte);
                        if (cnt_ff >= 3'd3) begin
                           word_in = {word_ff[23:0], rx_byte};
                        end
                        cnt_in = cnt_inc[2:0];
                     end else begin
                        push     = 1'b1;
                        job.kind = JOB_DONE;
                        if (rx_byte == crc_ff) begin
                           job.data = word_ff;
                        end else begin
                           job.status = ST_CRC;
                        end
                        cnt_in = 3'd0;
                     end
                  end
                  default: ;
               endcase
            end else begin
               if (!expired) begin
                  wait_in = wait_ff + TIMEOUT_WIDTH'(1);
               end else begin
                  cnt_in  = 3'd0;
                  wait_in = '0;
                  case (phase_ff)
                     PH_RD_ECHO: begin
                        crc_in  = 8'd0;
                        word_in = 32'd0;
                     end
                     PH_RD_REPLY: begin
                        push       = 1'b1;
                        job.kind   = JOB_DONE;
                        job.status = ST_TIMEOUT;
                     end
                     default: ;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= 3'd0;
         crc_ff   <= 8'd0;
         word_ff  <= 32'd0;
         wait_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         word_ff  <= word_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

>>> design/urde_queue.sv
// Short job queue between front and back ends.
// Depends on urde_pkg for the job type and depth.
module urde_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  urde_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output urde_pkg::job_type head
);
   import urde_pkg::*;

   job_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;

   assign full  = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/urde_back.sv
// Back end: expands queued jobs into result beats behind an output register,
// one per cycle unless stalled, building the datagram CRC bytewise. Depends on urde_pkg.
module urde_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  urde_pkg::job_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        out_kind,
   output logic [7:0]        tx_byte,
   output logic              last,
   output logic [31:0]       read_data,
   output logic [1:0]        status
);
   import urde_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  tx_ff, tx_in;
   logic        last_ff, last_in;
   logic [31:0] data_ff, data_in;
   logic [1:0]  status_ff, status_in;

   logic       load;
   logic       emit;
   logic       is_dgram;
   logic [2:0] last_idx;
   logic       at_last;
   logic [7:0] dg_byte;

   assign load     = !valid_ff || rsp_tready;
   assign emit     = load && !q_empty;
   assign is_dgram = (head.kind == JOB_WRITE) || (head.kind == JOB_READ);
   assign last_idx = (head.kind == JOB_WRITE) ? WR_LAST_IDX : RD_LAST_IDX;
   assign at_last  = (idx_ff == last_idx);
   assign pop      = emit && (!is_dgram || at_last);

   always_comb begin
      case (idx_ff)
         3'd0: dg_byte = SYNC_BYTE;
         3'd1: dg_byte = {6'd0, head.slave};
         3'd2: dg_byte = (head.kind == JOB_WRITE) ? (REG_WRITE_FLAG | {1'b0, head.reg_addr})
                                                  : {1'b0, head.reg_addr};
         3'd3: dg_byte = (head.kind == JOB_WRITE) ? head.data[31:24] : crc_ff;
         3'd4: dg_byte = head.data[23:16];
         3'd5: dg_byte = head.data[15:8];
         3'd6: dg_byte = head.data[7:0];
         default: dg_byte = crc_ff;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      valid_in  = load ? emit : valid_ff;
      kind_in   = kind_ff;
      tx_in     = tx_ff;
      last_in   = last_ff;
      data_in   = data_ff;
      status_in = status_ff;
      if (emit) begin
         if (is_dgram) begin
            kind_in   = OUT_TX;
            tx_in     = dg_byte;
            last_in   = at_last;
            data_in   = 32'd0;
            status_in = ST_OK;
            if (at_last) begin
               idx_in = 3'd0;
               crc_in = 8'd0;
            end else begin
               idx_in = idx_ff + 3'd1;
               crc_in = crc_feed(crc_ff, dg_byte);
            end
         end else begin
            kind_in   = (head.kind == JOB_DONE) ? OUT_READ_DONE : OUT_REFUSED;
            tx_in     = 8'd0;
            last_in   = 1'b0;
            data_in   = head.data;
            status_in = head.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         crc_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      last_ff   <= last_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign out_kind   = kind_ff;
   assign tx_byte    = tx_ff;
   assign last       = last_ff;
   assign read_data  = data_ff;
   assign status     = status_ff;

endmodule

>>> design/uart_register_datagram_engine.sv
// Top level of the UART register datagram engine: configuration registers,
// front end, job queue and back end. Depends on urde_pkg and the urde_ modules.
//
// Usage: req_ beats carry a command in req_tuser (write request, read request,
// received line byte, or one timer tick). A write request yields eight rsp_ beats
// of kind "transmit" (sync, slave address, register with bit 7 set, four data
// bytes MSB first, CRC-8), the last one flagged by rsp_tlast; a read request
// yields four. The engine then swallows the echo and, for a read, collects the
// 8-byte reply and returns one "read completed" beat with data and status
// (ok, CRC mismatch, timeout). A request while a transaction is open is answered
// with one "refused" beat.
// The first result beat passes through a queue slot and then the output register;
// datagram bytes then follow one per cycle while the receiver keeps rsp_tready high.
// Input beats are taken one per cycle while the 4-entry job queue has room; the
// front end updates the transaction state as each beat is accepted.
// When the receiver stalls, the output register holds its beat, the back end
// stops and jobs collect in the queue; req_tready drops once the queue is full.
// Reset (synchronous) empties the queue and output, returns to idle, sets the
// slave address to 0 and the timeout to 50 ticks.
module uart_register_datagram_engine #(
   parameter int unsigned TIMEOUT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Requests, received bytes and ticks.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [6:0] reg_addr, [38:7] write_data, [46:39] rx_byte, [47] zero
   input  logic [urde_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]                           req_tuser,
   // Results.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] tx_byte, [39:8] read_data, [41:40] status, [47:42] zero
   output logic [urde_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // [1:0] out_kind
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   // Configuration writes.
   input  logic                                 csr_we,
   input  logic                                 csr_addr,
   input  logic [urde_pkg::CSR_WIDTH-1:0]       csr_wdata
);
   import urde_pkg::*;

   logic [1:0]               slave_addr_ff, slave_addr_in;
   logic [TIMEOUT_WIDTH-1:0] timeout_ff, timeout_in;
   logic [31:0]              csr_wide;

   logic    push;
   job_type push_job;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   job_type head;

   logic [7:0]  tx_byte;
   logic [31:0] read_data;
   logic [1:0]  status;

   // Configuration: hold unless written; timeout sized to the counter width.
   assign csr_wide = {16'd0, csr_wdata};

   always_comb begin
      slave_addr_in = slave_addr_ff;
      timeout_in    = timeout_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SLAVE_ADDR: slave_addr_in = csr_wdata[1:0];
            CSR_TIMEOUT:    timeout_in    = csr_wide[TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= 2'd0;
         timeout_ff    <= TIMEOUT_WIDTH'(50);
      end else begin
         slave_addr_ff <= slave_addr_in;
         timeout_ff    <= timeout_in;
      end
   end

   // Front end: classify beats, advance echo/reply phases, queue jobs.
   urde_front #(
      .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .cmd           (req_tuser),
      .reg_addr      (req_tdata[6:0]),
      .write_data    (req_tdata[38:7]),
      .rx_byte       (req_tdata[46:39]),
      .slave_address (slave_addr_ff),
      .timeout_ticks (timeout_ff),
      .q_full        (q_full),
      .push          (push),
      .job           (push_job)
   );

   urde_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   // Back end: emit result beats through the output register.
   urde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_kind   (rsp_tuser),
      .tx_byte    (tx_byte),
      .last       (rsp_tlast),
      .read_data  (read_data),
      .status     (status)
   );

   assign rsp_tdata = {6'd0, status, read_data, tx_byte};

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(push && q_full))
      else $error("job pushed into full queue");

   // Only a transmit beat may close a datagram.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == OUT_TX)
      else $error("tlast on a non-transmit beat");

   // A refused request carries an all-zero payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == OUT_REFUSED |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("refused beat with payload");

   // A datagram leaves the queue only on its final byte.
   assert property (@(posedge clock) disable iff (reset)
      pop && (head.kind == JOB_WRITE || head.kind == JOB_READ) |=> rsp_tlast)
      else $error("datagram popped before its CRC byte");

endmodule
